// ===== hdl/exu_pkg.sv =====
package exu_pkg;

   // Storage sizes.
   localparam int MEM_BYTES = 4096;
   localparam int MEM_AW    = $clog2(MEM_BYTES);
   localparam int MEM_WORDS = MEM_BYTES / 4;
   localparam int WORD_AW   = MEM_AW - 2;
   localparam int NUM_REGS  = 32;
   localparam int REG_AW    = $clog2(NUM_REGS);

   // Architectural constants.
   localparam logic [31:0] SP_INIT     = 32'(MEM_BYTES - 4);
   localparam logic [4:0]  SHAMT_MASK  = 5'b1_1111;
   localparam int          UPPER_SHIFT = 12;
   localparam logic [31:0] JALR_MASK   = ~32'd1;
   localparam logic [REG_AW-1:0] REG_RA = REG_AW'(1);
   localparam logic [REG_AW-1:0] REG_SP = REG_AW'(2);

   // Command codes.
   localparam logic [5:0] CMD_RESTART = 6'd0;
   localparam logic [5:0] CMD_LUI     = 6'd1;
   localparam logic [5:0] CMD_AUIPC   = 6'd2;
   localparam logic [5:0] CMD_JAL     = 6'd3;
   localparam logic [5:0] CMD_JALR    = 6'd4;
   localparam logic [5:0] CMD_BEQ     = 6'd5;
   localparam logic [5:0] CMD_BNE     = 6'd6;
   localparam logic [5:0] CMD_BLT     = 6'd7;
   localparam logic [5:0] CMD_BGE     = 6'd8;
   localparam logic [5:0] CMD_BLTU    = 6'd9;
   localparam logic [5:0] CMD_BGEU    = 6'd10;
   localparam logic [5:0] CMD_LB      = 6'd11;
   localparam logic [5:0] CMD_LH      = 6'd12;
   localparam logic [5:0] CMD_LW      = 6'd13;
   localparam logic [5:0] CMD_LBU     = 6'd14;
   localparam logic [5:0] CMD_LHU     = 6'd15;
   localparam logic [5:0] CMD_SB      = 6'd16;
   localparam logic [5:0] CMD_SH      = 6'd17;
   localparam logic [5:0] CMD_SW      = 6'd18;
   localparam logic [5:0] CMD_ADDI    = 6'd19;
   localparam logic [5:0] CMD_SLTI    = 6'd20;
   localparam logic [5:0] CMD_SLTIU   = 6'd21;
   localparam logic [5:0] CMD_XORI    = 6'd22;
   localparam logic [5:0] CMD_ORI     = 6'd23;
   localparam logic [5:0] CMD_ANDI    = 6'd24;
   localparam logic [5:0] CMD_SLLI    = 6'd25;
   localparam logic [5:0] CMD_SRLI    = 6'd26;
   localparam logic [5:0] CMD_SRAI    = 6'd27;
   localparam logic [5:0] CMD_ADD     = 6'd28;
   localparam logic [5:0] CMD_SUB     = 6'd29;
   localparam logic [5:0] CMD_SLT     = 6'd30;
   localparam logic [5:0] CMD_SLTU    = 6'd31;
   localparam logic [5:0] CMD_XOR     = 6'd32;
   localparam logic [5:0] CMD_OR      = 6'd33;
   localparam logic [5:0] CMD_AND     = 6'd34;
   localparam logic [5:0] CMD_SLL     = 6'd35;
   localparam logic [5:0] CMD_SRL     = 6'd36;
   localparam logic [5:0] CMD_SRA     = 6'd37;
   localparam logic [5:0] CMD_FENCE   = 6'd38;
   localparam logic [5:0] CMD_FENCE_I = 6'd39;
   localparam logic [5:0] CMD_ECALL   = 6'd40;
   localparam logic [5:0] CMD_EBREAK  = 6'd41;

   // Status codes.
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_UNKNOWN = 2'd1;
   localparam logic [1:0] STAT_ECALL   = 2'd2;

   // Access sizes.
   localparam logic [1:0] SIZE_B = 2'd0;
   localparam logic [1:0] SIZE_H = 2'd1;
   localparam logic [1:0] SIZE_W = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_ENTRY_PC = 1'b0;
   localparam logic CSR_RA_INIT  = 1'b1;

   // Register file retire port.
   typedef struct packed {
      logic              en;
      logic              restart;
      logic [REG_AW-1:0] idx;
      logic [31:0]       val;
   } rf_wr_type;

   // Data memory request.
   typedef struct packed {
      logic              rd;
      logic              wr;
      logic [MEM_AW-1:0] addr;
      logic [1:0]        size;
      logic [31:0]       data;
   } mem_req_type;

   // Register value right after a restart.
   function automatic logic [31:0] restart_value(input logic [REG_AW-1:0] idx,
                                                 input logic [31:0] ra);
      logic [31:0] v;
      v = 32'd0;
      if (idx == REG_RA) v = ra;
      else if (idx == REG_SP) v = SP_INIT;
      return v;
   endfunction

endpackage

// ===== hdl/exu_if.sv =====
interface exu_req_if;
   logic        valid;
   logic        ready;
   logic [5:0]  cmd;
   logic [4:0]  dest_reg;
   logic [4:0]  src_reg_a;
   logic [4:0]  src_reg_b;
   logic [20:0] imm_raw;

   modport source (output valid, cmd, dest_reg, src_reg_a, src_reg_b, imm_raw,
                   input ready);
   modport sink   (input valid, cmd, dest_reg, src_reg_a, src_reg_b, imm_raw,
                   output ready);
endinterface

interface exu_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] next_pc;
   logic        reg_written;
   logic [4:0]  written_index;
   logic [31:0] written_value;
   logic [1:0]  status;
   logic        finished;

   modport source (output valid, next_pc, reg_written, written_index, written_value,
                   status, finished, input ready);
   modport sink   (input valid, next_pc, reg_written, written_index, written_value,
                   status, finished, output ready);
endinterface

// ===== hdl/exu_ram.sv =====
module exu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/exu_regfile.sv =====
module exu_regfile (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [exu_pkg::REG_AW-1:0] rd_addr_a,
   input  logic [exu_pkg::REG_AW-1:0] rd_addr_b,
   input  logic [exu_pkg::REG_AW-1:0] idx_a,
   input  logic [exu_pkg::REG_AW-1:0] idx_b,
   input  exu_pkg::rf_wr_type        wr,
   input  logic [31:0]               ra_init,
   output logic [31:0]               data_a,
   output logic [31:0]               data_b
);
   import exu_pkg::*;

   logic [NUM_REGS-1:0] valid_ff;
   logic                restarted_ff;
   logic [31:0]         rst_ra_ff;
   logic                lw_valid_ff;
   logic [REG_AW-1:0]   lw_idx_ff;
   logic [31:0]         lw_val_ff;
   logic [31:0]         ram_a;
   logic [31:0]         ram_b;

   // Two copies so both source operands are read in the same cycle.
   exu_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_bank_a (
      .clock(clock), .wr_en(wr.en), .wr_addr(wr.idx), .wr_data(wr.val),
      .rd_en(rd_en), .rd_addr(rd_addr_a), .rd_data(ram_a));

   exu_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_bank_b (
      .clock(clock), .wr_en(wr.en), .wr_addr(wr.idx), .wr_data(wr.val),
      .rd_en(rd_en), .rd_addr(rd_addr_b), .rd_data(ram_b));

   // Valid bits mark entries written since the last restart; others read the
   // restart value if restarted, else 0. Last write is kept for same-edge reads.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         restarted_ff <= 1'b0;
         rst_ra_ff    <= 32'd0;
         lw_valid_ff  <= 1'b0;
      end else if (wr.restart) begin
         valid_ff     <= '0;
         restarted_ff <= 1'b1;
         rst_ra_ff    <= ra_init;
         lw_valid_ff  <= 1'b0;
      end else if (wr.en) begin
         valid_ff[wr.idx] <= 1'b1;
         lw_valid_ff      <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         lw_idx_ff <= wr.idx;
         lw_val_ff <= wr.val;
      end
   end

   // Operand selection.
   always_comb begin
      if (idx_a == '0) data_a = 32'd0;
      else if (lw_valid_ff && lw_idx_ff == idx_a) data_a = lw_val_ff;
      else if (valid_ff[idx_a]) data_a = ram_a;
      else if (restarted_ff) data_a = restart_value(idx_a, rst_ra_ff);
      else data_a = 32'd0;

      if (idx_b == '0) data_b = 32'd0;
      else if (lw_valid_ff && lw_idx_ff == idx_b) data_b = lw_val_ff;
      else if (valid_ff[idx_b]) data_b = ram_b;
      else if (restarted_ff) data_b = restart_value(idx_b, rst_ra_ff);
      else data_b = 32'd0;
   end

   // A restart and a register write never retire together.
   assert property (@(posedge clock) disable iff (reset) !(wr.en && wr.restart))
      else $error("restart and write retired in the same cycle");
   // x0 is never written.
   assert property (@(posedge clock) disable iff (reset) wr.en |-> wr.idx != '0)
      else $error("write to x0");
   // After a restart no entry holds a stale value.
   assert property (@(posedge clock) disable iff (reset) wr.restart |=> valid_ff == '0)
      else $error("valid bits not cleared by restart");
endmodule

// ===== hdl/exu_dmem.sv =====
module exu_dmem (
   input  logic                 clock,
   input  logic                 reset,
   input  exu_pkg::mem_req_type req,
   output logic                 busy,
   output logic [31:0]          load_word
);
   import exu_pkg::*;

   logic               clearing_ff;
   logic [WORD_AW-1:0] clr_cnt_ff;
   logic [1:0]         off_ff;
   logic [1:0]         off;
   logic [WORD_AW-1:0] word;
   logic [7:0]         lane_rd  [4];
   logic [WORD_AW-1:0] lane_adr [4];
   logic [7:0]         lane_wd  [4];
   logic               lane_we  [4];

   assign off  = req.addr[1:0];
   assign word = req.addr[MEM_AW-1:2];
   assign busy = clearing_ff;

   // Zero sweep over all words after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == WORD_AW'(MEM_WORDS - 1)) clearing_ff <= 1'b0;
      end
   end

   // Byte k of an access lives in lane (addr + k) mod 4, one word further on
   // for lanes below the start offset.
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         logic [1:0] k;
         logic       en;
         k = 2'(l) - off;
         case (req.size)
            SIZE_B:  en = (k == 2'd0);
            SIZE_H:  en = (k <= 2'd1);
            SIZE_W:  en = 1'b1;
            default: en = 1'b0;
         endcase
         lane_adr[l] = (2'(l) < off) ? word + 1'b1 : word;
         lane_wd[l]  = req.data[8*k +: 8];
         lane_we[l]  = req.wr && en;
         if (clearing_ff) begin
            lane_adr[l] = clr_cnt_ff;
            lane_wd[l]  = 8'd0;
            lane_we[l]  = 1'b1;
         end
      end
   end

   for (genvar l = 0; l < 4; l++) begin : g_lane
      exu_ram #(.WIDTH(8), .DEPTH(MEM_WORDS)) u_lane (
         .clock(clock), .wr_en(lane_we[l]), .wr_addr(lane_adr[l]),
         .wr_data(lane_wd[l]), .rd_en(req.rd), .rd_addr(lane_adr[l]),
         .rd_data(lane_rd[l]));
   end

   always_ff @(posedge clock) begin
      if (req.rd) off_ff <= off;
   end

   // Rotate the lanes back into little-endian byte order.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         load_word[8*k +: 8] = lane_rd[2'(k) + off_ff];
      end
   end
endmodule

// ===== hdl/rv32i_execute_unit_core.sv =====
// RV32I execute unit: one pre-decoded instruction per beat.
// The request channel carries cmd, register indexes and the raw immediate;
// a beat moves on a rising edge with valid and ready high. The response
// channel returns one beat per instruction: next pc, the register write,
// status and the finished flag. The configuration port writes entry_pc
// (index 0) and return_address_init (index 1); the user must write them only
// while the unit is idle, which the unit does not enforce. An instruction is
// accepted into the execute stage and executes there (operands come from the
// register file RAMs read at accept, loads start their data memory read);
// its response is registered into the output stage when it leaves execute,
// which a stalled response side can hold back. Loads finish in the output
// stage. A new beat can be accepted every cycle unless execute is held back.
// The register file is written when the response beat leaves; the data memory
// is written when a store moves from execute into the output stage. Results
// still in flight are forwarded to the execute stage.
// After reset the data memory is zeroed one word per cycle, all MEM_BYTES/4
// words (1024), with req ready low. If the response side stalls, the
// output register holds and the execute stage and request side back up.
module rv32i_execute_unit_core (
   input  logic              clock,
   input  logic              reset,
   exu_req_if.sink           req_bus,
   exu_rsp_if.source         rsp_bus,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [31:0]       csr_wr_data
);
   import exu_pkg::*;

   // Configuration.
   logic [31:0] entry_pc_ff;
   logic [31:0] ra_init_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_pc_ff <= 32'd0;
         ra_init_ff  <= 32'd0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ENTRY_PC: entry_pc_ff <= csr_wr_data;
            CSR_RA_INIT:  ra_init_ff  <= csr_wr_data;
            default:      ;
         endcase
      end
   end

   // Stage and handshake control.
   logic        accept;
   logic        b_adv;
   logic        retire;
   logic        mem_busy;
   logic        b_valid_ff;
   logic        c_valid_ff;

   assign b_adv   = b_valid_ff && (!c_valid_ff || rsp_bus.ready);
   assign retire  = c_valid_ff && rsp_bus.ready;
   assign req_bus.ready = !mem_busy && (!b_valid_ff || b_adv);
   assign accept  = req_bus.valid && req_bus.ready;

   // Execute stage registers.
   logic [5:0]        b_cmd_ff;
   logic [REG_AW-1:0] b_rd_ff;
   logic [REG_AW-1:0] b_rs1_ff;
   logic [REG_AW-1:0] b_rs2_ff;
   logic [20:0]       b_imm_ff;

   always_ff @(posedge clock) begin
      if (reset) b_valid_ff <= 1'b0;
      else if (accept) b_valid_ff <= 1'b1;
      else if (b_adv) b_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_cmd_ff <= req_bus.cmd;
         b_rd_ff  <= req_bus.dest_reg;
         b_rs1_ff <= req_bus.src_reg_a;
         b_rs2_ff <= req_bus.src_reg_b;
         b_imm_ff <= req_bus.imm_raw;
      end
   end

   // Output stage registers.
   logic [31:0]       c_npc_ff;
   logic              c_wr_ff;
   logic [REG_AW-1:0] c_idx_ff;
   logic [31:0]       c_val_ff;
   logic              c_load_ff;
   logic [5:0]        c_cmd_ff;
   logic [1:0]        c_status_ff;
   logic              c_fin_ff;
   logic              c_restart_ff;
   logic [31:0]       c_res;
   logic [31:0]       load_word;

   // Register file and retire port.
   rf_wr_type   rf_wr;
   logic [31:0] rf_a;
   logic [31:0] rf_b;

   assign rf_wr.en      = retire && c_wr_ff;
   assign rf_wr.restart = retire && c_restart_ff;
   assign rf_wr.idx     = c_idx_ff;
   assign rf_wr.val     = c_res;

   exu_regfile u_regfile (
      .clock(clock), .reset(reset), .rd_en(accept),
      .rd_addr_a(req_bus.src_reg_a), .rd_addr_b(req_bus.src_reg_b),
      .idx_a(b_rs1_ff), .idx_b(b_rs2_ff), .wr(rf_wr), .ra_init(ra_init_ff),
      .data_a(rf_a), .data_b(rf_b));

   // Forward the instruction waiting in the output stage.
   logic [31:0] a;
   logic [31:0] b;

   always_comb begin
      a = rf_a;
      b = rf_b;
      if (c_valid_ff && c_restart_ff) begin
         a = restart_value(b_rs1_ff, ra_init_ff);
         b = restart_value(b_rs2_ff, ra_init_ff);
      end else if (c_valid_ff && c_wr_ff) begin
         if (c_idx_ff == b_rs1_ff) a = c_res;
         if (c_idx_ff == b_rs2_ff) b = c_res;
      end
   end

   // Architectural pc and halt flag.
   logic [31:0] pc_ff;
   logic        halted_ff;

   // Execute.
   logic [31:0] imm_i;
   logic [31:0] imm_b;
   logic [31:0] imm_j;
   logic [31:0] imm_u;
   logic [31:0] pc4;
   logic [31:0] br_tgt;
   logic [31:0] addr;
   logic [31:0] npc;
   logic [31:0] res;
   logic        wr;
   logic        is_load;
   logic        restart;
   logic        halt_n;
   logic [1:0]  status;
   logic        slt_ab;
   logic        slt_ai;
   mem_req_type mreq;

   assign imm_i  = {{20{b_imm_ff[11]}}, b_imm_ff[11:0]};
   assign imm_b  = {{19{b_imm_ff[12]}}, b_imm_ff[12:0]};
   assign imm_j  = {{11{b_imm_ff[20]}}, b_imm_ff[20:0]};
   assign imm_u  = {b_imm_ff[19:0], 12'd0};
   assign pc4    = pc_ff + 32'd4;
   assign br_tgt = pc_ff + imm_b;
   assign addr   = a + imm_i;
   assign slt_ab = $signed(a) < $signed(b);
   assign slt_ai = $signed(a) < $signed(imm_i);

   always_comb begin
      npc     = pc4;
      res     = 32'd0;
      wr      = 1'b0;
      is_load = 1'b0;
      restart = 1'b0;
      halt_n  = halted_ff;
      status  = STAT_OK;
      mreq.rd   = 1'b0;
      mreq.wr   = 1'b0;
      mreq.addr = addr[MEM_AW-1:0];
      mreq.size = SIZE_W;
      mreq.data = b;
      case (b_cmd_ff)
         CMD_RESTART: begin
            npc     = entry_pc_ff;
            restart = 1'b1;
            halt_n  = 1'b0;
         end
         CMD_LUI:   begin res = imm_u; wr = 1'b1; end
         CMD_AUIPC: begin res = imm_u + pc_ff; wr = 1'b1; end
         CMD_JAL:   begin res = pc4; wr = 1'b1; npc = pc_ff + imm_j; end
         CMD_JALR:  begin res = pc4; wr = 1'b1; npc = addr & JALR_MASK; end
         CMD_BEQ:   if (a == b) npc = br_tgt;
         CMD_BNE:   if (a != b) npc = br_tgt;
         CMD_BLT:   if (slt_ab) npc = br_tgt;
         CMD_BGE:   if (!slt_ab) npc = br_tgt;
         CMD_BLTU:  if (a < b) npc = br_tgt;
         CMD_BGEU:  if (a >= b) npc = br_tgt;
         CMD_LB, CMD_LH, CMD_LW, CMD_LBU, CMD_LHU: begin
            wr      = 1'b1;
            is_load = 1'b1;
            mreq.rd = b_adv;
         end
         CMD_SB: begin mreq.wr = b_adv; mreq.size = SIZE_B; end
         CMD_SH: begin mreq.wr = b_adv; mreq.size = SIZE_H; end
         CMD_SW: begin mreq.wr = b_adv; mreq.size = SIZE_W; end
         CMD_ADDI:  begin res = addr; wr = 1'b1; end
         CMD_SLTI:  begin res = {31'd0, slt_ai}; wr = 1'b1; end
         CMD_SLTIU: begin res = {31'd0, a < imm_i}; wr = 1'b1; end
         CMD_XORI:  begin res = a ^ imm_i; wr = 1'b1; end
         CMD_ORI:   begin res = a | imm_i; wr = 1'b1; end
         CMD_ANDI:  begin res = a & imm_i; wr = 1'b1; end
         CMD_SLLI:  begin res = a << (imm_i[4:0] & SHAMT_MASK); wr = 1'b1; end
         CMD_SRLI:  begin res = a >> (imm_i[4:0] & SHAMT_MASK); wr = 1'b1; end
         CMD_SRAI:  begin
            res = 32'($signed(a) >>> (imm_i[4:0] & SHAMT_MASK));
            wr  = 1'b1;
         end
         CMD_ADD:   begin res = a + b; wr = 1'b1; end
         CMD_SUB:   begin res = a - b; wr = 1'b1; end
         CMD_SLT:   begin res = {31'd0, slt_ab}; wr = 1'b1; end
         CMD_SLTU:  begin res = {31'd0, a < b}; wr = 1'b1; end
         CMD_XOR:   begin res = a ^ b; wr = 1'b1; end
         CMD_OR:    begin res = a | b; wr = 1'b1; end
         CMD_AND:   begin res = a & b; wr = 1'b1; end
         CMD_SLL:   begin res = a << (b[4:0] & SHAMT_MASK); wr = 1'b1; end
         CMD_SRL:   begin res = a >> (b[4:0] & SHAMT_MASK); wr = 1'b1; end
         CMD_SRA:   begin
            res = 32'($signed(a) >>> (b[4:0] & SHAMT_MASK));
            wr  = 1'b1;
         end
         CMD_FENCE, CMD_FENCE_I: ;
         CMD_ECALL:  status = STAT_ECALL;
         CMD_EBREAK: halt_n = 1'b1;
         default: begin
            status = STAT_UNKNOWN;
            npc    = pc_ff;
         end
      endcase
   end

   exu_dmem u_dmem (
      .clock(clock), .reset(reset), .req(mreq), .busy(mem_busy),
      .load_word(load_word));

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= 32'd0;
         halted_ff <= 1'b0;
      end else if (b_adv) begin
         pc_ff     <= npc;
         halted_ff <= halt_n;
      end
   end

   // Output stage.
   always_ff @(posedge clock) begin
      if (reset) c_valid_ff <= 1'b0;
      else if (b_adv) c_valid_ff <= 1'b1;
      else if (retire) c_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         c_npc_ff     <= npc;
         c_wr_ff      <= wr && (b_rd_ff != '0);
         c_idx_ff     <= (wr && (b_rd_ff != '0)) ? b_rd_ff : '0;
         c_val_ff     <= res;
         c_load_ff    <= is_load;
         c_cmd_ff     <= b_cmd_ff;
         c_status_ff  <= status;
         c_fin_ff     <= halt_n;
         c_restart_ff <= restart;
      end
   end

   // Load extension and result masking.
   always_comb begin
      logic [31:0] ld;
      case (c_cmd_ff)
         CMD_LB:  ld = {{24{load_word[7]}}, load_word[7:0]};
         CMD_LH:  ld = {{16{load_word[15]}}, load_word[15:0]};
         CMD_LBU: ld = {24'd0, load_word[7:0]};
         CMD_LHU: ld = {16'd0, load_word[15:0]};
         default: ld = load_word;
      endcase
      if (!c_wr_ff) c_res = 32'd0;
      else if (c_load_ff) c_res = ld;
      else c_res = c_val_ff;
   end

   assign rsp_bus.valid         = c_valid_ff;
   assign rsp_bus.next_pc       = c_npc_ff;
   assign rsp_bus.reg_written   = c_wr_ff;
   assign rsp_bus.written_index = c_idx_ff;
   assign rsp_bus.written_value = c_res;
   assign rsp_bus.status        = c_status_ff;
   assign rsp_bus.finished      = c_fin_ff;

   // No beat is taken while the data memory is being zeroed.
   assert property (@(posedge clock) disable iff (reset) mem_busy |-> !req_bus.ready)
      else $error("request accepted during memory clear");
   // A restart leaving execute loads the entry pc.
   assert property (@(posedge clock) disable iff (reset)
      b_adv && b_cmd_ff == CMD_RESTART |=> pc_ff == entry_pc_ff)
      else $error("restart did not load the entry pc");
   // An unknown command leaves the pc where it was.
   assert property (@(posedge clock) disable iff (reset)
      b_adv && status == STAT_UNKNOWN |=> pc_ff == $past(pc_ff))
      else $error("unknown command moved the pc");
endmodule

// ===== tb/sv/tb_rv32i_execute_unit_core.sv =====
module tb_rv32i_execute_unit_core;
   import exu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // One expected response beat.
   typedef struct {
      logic [31:0] next_pc;
      logic        reg_written;
      logic [4:0]  written_index;
      logic [31:0] written_value;
      logic [1:0]  status;
      logic        finished;
   } retire_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_index;
   logic [31:0] csr_wr_data;

   exu_req_if req_bus();
   exu_rsp_if rsp_bus();

   rv32i_execute_unit_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   // Architectural copy of the unit, kept in step with accepted beats.
   logic [31:0] arch_regs [NUM_REGS];
   logic [31:0] arch_pc;
   logic [7:0]  arch_mem [MEM_BYTES];
   logic        arch_halted;
   logic [31:0] cfg_entry_pc;
   logic [31:0] cfg_ra_init;

   retire_type pending_retires[$];
   int         fail_count;
   int         burst_left;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [31:0] sign_extend(input logic [31:0] raw, input int sign_bit);
      logic [31:0] field_mask;
      logic [31:0] v;
      field_mask = (32'd2 << sign_bit) - 32'd1;
      v = raw & field_mask;
      if (v[sign_bit]) v = v | ~field_mask;
      return v;
   endfunction

   function automatic logic signed_less(input logic [31:0] a, input logic [31:0] b);
      return $signed(a) < $signed(b);
   endfunction

   function automatic logic [31:0] load_bytes(input logic [31:0] addr, input int nbytes);
      logic [31:0] v;
      logic [31:0] byte_addr;
      v = 32'd0;
      for (int i = 0; i < nbytes; i++) begin
         byte_addr = addr + i;
         v = v | (32'(arch_mem[byte_addr[MEM_AW-1:0]]) << (8 * i));
      end
      return v;
   endfunction

   task automatic store_bytes(input logic [31:0] addr, input logic [31:0] val,
                              input int nbytes);
      logic [31:0] byte_addr;
      for (int i = 0; i < nbytes; i++) begin
         byte_addr = addr + i;
         arch_mem[byte_addr[MEM_AW-1:0]] = val[8*i +: 8];
      end
   endtask

   // Execute one instruction on the architectural copy and return its retire beat.
   task automatic execute_instr(input logic [5:0] cmd, input logic [4:0] rd,
                                input logic [4:0] rs1, input logic [4:0] rs2,
                                input logic [20:0] imm, output retire_type r);
      logic [31:0] a, b, raw, pc, npc, immi, immb, addr, res;
      logic        wr;
      logic [1:0]  st;
      a    = (rs1 == 5'd0) ? 32'd0 : arch_regs[rs1];
      b    = (rs2 == 5'd0) ? 32'd0 : arch_regs[rs2];
      raw  = 32'(imm);
      pc   = arch_pc;
      npc  = pc + 32'd4;
      immi = sign_extend(raw, 11);
      immb = sign_extend(raw, 12);
      addr = a + immi;
      res  = 32'd0;
      wr   = 1'b0;
      st   = STAT_OK;
      case (cmd)
         CMD_RESTART: begin
            for (int i = 0; i < NUM_REGS; i++) arch_regs[i] = 32'd0;
            arch_regs[2] = SP_INIT;
            arch_regs[1] = cfg_ra_init;
            arch_halted  = 1'b0;
            npc = cfg_entry_pc;
         end
         CMD_LUI: begin res = (raw & 32'hFFFFF) << UPPER_SHIFT; wr = 1'b1; end
         CMD_AUIPC: begin res = ((raw & 32'hFFFFF) << UPPER_SHIFT) + pc; wr = 1'b1; end
         CMD_JAL: begin res = pc + 32'd4; wr = 1'b1; npc = pc + sign_extend(raw, 20); end
         CMD_JALR: begin res = pc + 32'd4; wr = 1'b1; npc = (a + immi) & JALR_MASK; end
         CMD_BEQ:  if (a == b) npc = pc + immb;
         CMD_BNE:  if (a != b) npc = pc + immb;
         CMD_BLT:  if (signed_less(a, b)) npc = pc + immb;
         CMD_BGE:  if (!signed_less(a, b)) npc = pc + immb;
         CMD_BLTU: if (a < b) npc = pc + immb;
         CMD_BGEU: if (a >= b) npc = pc + immb;
         CMD_LB:  begin res = sign_extend(load_bytes(addr, 1), 7); wr = 1'b1; end
         CMD_LH:  begin res = sign_extend(load_bytes(addr, 2), 15); wr = 1'b1; end
         CMD_LW:  begin res = load_bytes(addr, 4); wr = 1'b1; end
         CMD_LBU: begin res = load_bytes(addr, 1); wr = 1'b1; end
         CMD_LHU: begin res = load_bytes(addr, 2); wr = 1'b1; end
         CMD_SB: store_bytes(addr, b, 1);
         CMD_SH: store_bytes(addr, b, 2);
         CMD_SW: store_bytes(addr, b, 4);
         CMD_ADDI:  begin res = a + immi; wr = 1'b1; end
         CMD_SLTI:  begin res = 32'(signed_less(a, immi)); wr = 1'b1; end
         CMD_SLTIU: begin res = 32'(a < immi); wr = 1'b1; end
         CMD_XORI:  begin res = a ^ immi; wr = 1'b1; end
         CMD_ORI:   begin res = a | immi; wr = 1'b1; end
         CMD_ANDI:  begin res = a & immi; wr = 1'b1; end
         CMD_SLLI:  begin res = a << (immi[4:0] & SHAMT_MASK); wr = 1'b1; end
         CMD_SRLI:  begin res = a >> (immi[4:0] & SHAMT_MASK); wr = 1'b1; end
         CMD_SRAI:  begin res = $signed(a) >>> (immi[4:0] & SHAMT_MASK); wr = 1'b1; end
         CMD_ADD:   begin res = a + b; wr = 1'b1; end
         CMD_SUB:   begin res = a - b; wr = 1'b1; end
         CMD_SLT:   begin res = 32'(signed_less(a, b)); wr = 1'b1; end
         CMD_SLTU:  begin res = 32'(a < b); wr = 1'b1; end
         CMD_XOR:   begin res = a ^ b; wr = 1'b1; end
         CMD_OR:    begin res = a | b; wr = 1'b1; end
         CMD_AND:   begin res = a & b; wr = 1'b1; end
         CMD_SLL:   begin res = a << (b[4:0] & SHAMT_MASK); wr = 1'b1; end
         CMD_SRL:   begin res = a >> (b[4:0] & SHAMT_MASK); wr = 1'b1; end
         CMD_SRA:   begin res = $signed(a) >>> (b[4:0] & SHAMT_MASK); wr = 1'b1; end
         CMD_FENCE, CMD_FENCE_I: ;
         CMD_ECALL:  st = STAT_ECALL;
         CMD_EBREAK: arch_halted = 1'b1;
         default: begin
            st  = STAT_UNKNOWN;
            npc = pc;
         end
      endcase
      // Writes to x0 are dropped and reported as no write.
      if (wr && rd != 5'd0) begin
         arch_regs[rd] = res;
      end else begin
         wr  = 1'b0;
         rd  = 5'd0;
         res = 32'd0;
      end
      arch_pc         = npc;
      r.next_pc       = npc;
      r.reg_written   = wr;
      r.written_index = rd;
      r.written_value = res;
      r.status        = st;
      r.finished      = arch_halted;
   endtask

   // Send one instruction beat; the sender runs in bursts with random gaps.
   task automatic send_instr(input logic [5:0] cmd, input logic [4:0] rd,
                             input logic [4:0] rs1, input logic [4:0] rs2,
                             input logic [20:0] imm);
      retire_type r;
      int         gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= cmd;
      req_bus.dest_reg  <= rd;
      req_bus.src_reg_a <= rs1;
      req_bus.src_reg_b <= rs2;
      req_bus.imm_raw   <= imm;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      execute_instr(cmd, rd, rs1, rs2, imm, r);
      pending_retires.push_back(r);
   endtask

   // Lower valid and wait until every response beat has come back.
   task automatic drain;
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_retires.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_ENTRY_PC) cfg_entry_pc = val;
      else cfg_ra_init = val;
   endtask

   task automatic send_random_instr;
      int          pick;
      logic [5:0]  cmd;
      logic [4:0]  rs1;
      logic [20:0] imm;
      pick = $urandom_range(0, 99);
      if (pick < 2) cmd = CMD_RESTART;
      else if (pick < 9) cmd = 6'($urandom_range(42, 63));
      else cmd = 6'($urandom_range(1, 41));
      // Favor a few base registers so loads often see earlier stores.
      rs1 = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 2)) : 5'($urandom);
      imm = 21'($urandom);
      send_instr(cmd, 5'($urandom), rs1, 5'($urandom), imm);
   endtask

   task automatic test_upper_and_jumps;
      send_instr(CMD_LUI,   5'd5,  5'd0, 5'd0, 21'h1FFFFF);
      send_instr(CMD_ADDI,  5'd6,  5'd0, 5'd0, 21'h0007FF);
      send_instr(CMD_ADDI,  5'd7,  5'd0, 5'd0, 21'h1FF800);
      send_instr(CMD_AUIPC, 5'd8,  5'd0, 5'd0, 21'h000001);
      send_instr(CMD_JAL,   5'd31, 5'd0, 5'd0, 21'h1FFFFC);
      send_instr(CMD_JALR,  5'd9,  5'd6, 5'd0, 21'h000801);
   endtask

   task automatic test_branches;
      for (int c = CMD_BEQ; c <= CMD_BGEU; c++) begin
         send_instr(6'(c), 5'd0, 5'd5, 5'd6, 21'h001FFE);
         send_instr(6'(c), 5'd0, 5'd6, 5'd6, 21'h000FFF);
      end
   endtask

   // Word store at the top of memory wraps around to address zero.
   task automatic test_memory;
      send_instr(CMD_SW,  5'd0,  5'd0, 5'd5, 21'h000FFE);
      send_instr(CMD_SH,  5'd0,  5'd0, 5'd7, 21'h000004);
      send_instr(CMD_SB,  5'd0,  5'd0, 5'd6, 21'h000007);
      send_instr(CMD_LB,  5'd10, 5'd0, 5'd0, 21'h000007);
      send_instr(CMD_LH,  5'd11, 5'd0, 5'd0, 21'h000FFF);
      send_instr(CMD_LW,  5'd12, 5'd0, 5'd0, 21'h000FFE);
      send_instr(CMD_LBU, 5'd13, 5'd0, 5'd0, 21'h000007);
      send_instr(CMD_LHU, 5'd14, 5'd0, 5'd0, 21'h000004);
   endtask

   task automatic test_alu;
      for (int c = CMD_ADDI; c <= CMD_SRA; c++)
         send_instr(6'(c), 5'd15, 5'd5, 5'd7, 21'h1FF83F);
      send_instr(CMD_ADD, 5'd0, 5'd5, 5'd6, 21'h0);
   endtask

   task automatic test_system;
      send_instr(CMD_FENCE,   5'd0,  5'd0, 5'd0, 21'h0);
      send_instr(CMD_FENCE_I, 5'd0,  5'd0, 5'd0, 21'h0);
      send_instr(CMD_ECALL,   5'd0,  5'd0, 5'd0, 21'h0);
      send_instr(CMD_EBREAK,  5'd0,  5'd0, 5'd0, 21'h0);
      send_instr(CMD_ADDI,    5'd16, 5'd2, 5'd0, 21'h1);
      send_instr(6'd63,       5'd17, 5'd1, 5'd2, 21'h1FFFFF);
      send_instr(CMD_RESTART, 5'd0,  5'd0, 5'd0, 21'h0);
      send_instr(CMD_LW,      5'd3,  5'd2, 5'd0, 21'h000004);
   endtask

   task automatic test_random(input int count);
      repeat (count) send_random_instr();
   endtask

   // Receiver ready follows a pattern of modes: open, random and mostly stalled.
   int ready_mode;
   int ready_left;
   int ready_tick;
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= $urandom_range(0, 2);
         ready_left <= $urandom_range(5, 60);
      end else begin
         ready_left <= ready_left - 1;
      end
      ready_tick <= ready_tick + 1;
      case (ready_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= 1'($urandom);
         default: rsp_bus.ready <= (ready_tick % 5 == 0);
      endcase
   end

   // Compare each response beat with the oldest expectation.
   always @(posedge clock) begin
      retire_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_retires.size() == 0) begin
            $error("response beat with no instruction outstanding");
            fail_count++;
         end else begin
            e = pending_retires.pop_front();
            if (rsp_bus.next_pc !== e.next_pc) begin
               $error("next_pc expected %h actual %h", e.next_pc, rsp_bus.next_pc);
               fail_count++;
            end
            if (rsp_bus.reg_written !== e.reg_written) begin
               $error("reg_written expected %b actual %b", e.reg_written,
                      rsp_bus.reg_written);
               fail_count++;
            end
            if (rsp_bus.written_index !== e.written_index) begin
               $error("written_index expected %0d actual %0d", e.written_index,
                      rsp_bus.written_index);
               fail_count++;
            end
            if (rsp_bus.written_value !== e.written_value) begin
               $error("written_value expected %h actual %h", e.written_value,
                      rsp_bus.written_value);
               fail_count++;
            end
            if (rsp_bus.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_bus.status);
               fail_count++;
            end
            if (rsp_bus.finished !== e.finished) begin
               $error("finished expected %b actual %b", e.finished, rsp_bus.finished);
               fail_count++;
            end
         end
      end
   end

   initial begin
      fail_count = 0;
      burst_left = 0;
      ready_mode = 0;
      ready_left = 0;
      ready_tick = 0;
      for (int i = 0; i < NUM_REGS; i++) arch_regs[i] = 32'd0;
      for (int i = 0; i < MEM_BYTES; i++) arch_mem[i] = 8'd0;
      arch_pc      = 32'd0;
      arch_halted  = 1'b0;
      cfg_entry_pc = 32'd0;
      cfg_ra_init  = 32'd0;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_ENTRY_PC;
      csr_wr_data       = 32'd0;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_FENCE;
      req_bus.dest_reg  = 5'd0;
      req_bus.src_reg_a = 5'd0;
      req_bus.src_reg_b = 5'd0;
      req_bus.imm_raw   = 21'd0;
      rsp_bus.ready     = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_csr(CSR_ENTRY_PC, 32'd0);
      write_csr(CSR_RA_INIT, 32'd0);
      test_upper_and_jumps();
      test_branches();
      test_memory();
      test_alu();
      test_system();
      drain();

      write_csr(CSR_ENTRY_PC, 32'hFFFF_FFFF);
      write_csr(CSR_RA_INIT, 32'hFFFF_FFFF);
      test_random(450);
      drain();

      write_csr(CSR_ENTRY_PC, $urandom);
      write_csr(CSR_RA_INIT, $urandom);
      test_random(450);
      drain();

      write_csr(CSR_ENTRY_PC, 32'h0000_1000);
      write_csr(CSR_RA_INIT, 32'h8000_0000);
      test_random(450);
      drain();
      repeat (10) @(posedge clock);

      if (fail_count == 0 && pending_retires.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== rv32i_execute_unit_core.f =====
hdl/exu_pkg.sv
hdl/exu_if.sv
hdl/exu_ram.sv
hdl/exu_regfile.sv
hdl/exu_dmem.sv
hdl/rv32i_execute_unit_core.sv
tb/sv/tb_rv32i_execute_unit_core.sv
